[sv/handle_keyed_io_statistics_table_unit_defines.svh]
// assertion macros for the handle keyed i/o statistics table
// used at the end of the top level, expects clk and rst in scope
`ifndef HANDLE_KEYED_IO_STATISTICS_TABLE_UNIT_DEFINES_SVH
`define HANDLE_KEYED_IO_STATISTICS_TABLE_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define HKST_IMPLY(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition must never be seen
`define HKST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/hkst_pkg.sv]
// shared types and constants of the handle keyed i/o statistics table
// no dependencies
package hkst_pkg;

  // operation codes
  localparam logic [2:0] OP_OPEN = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_SEEK = 3'd2;
  localparam logic [2:0] OP_MAP  = 3'd3;
  localparam logic [2:0] OP_VIEW = 3'd4;
  localparam logic [2:0] OP_STAT = 3'd5;

  // default sizes
  localparam int FILE_ENTRIES_DEF = 512;
  localparam int HANDLE_SLOTS_DEF = 4096;
  localparam int PROBE_LIMIT_DEF  = 8;
  localparam int SIZE_BUCKETS_DEF = 6;

  // record number width fixed by the ports
  localparam int REC_W = 9;

  // counter layout within one record, matches the statistic selector
  localparam logic [4:0] CNT_OPENS    = 5'd0;
  localparam logic [4:0] CNT_READS    = 5'd1;
  localparam logic [4:0] CNT_BYTES    = 5'd2;
  localparam logic [4:0] CNT_TICKS    = 5'd3;
  localparam logic [4:0] CNT_SEEKS    = 5'd4;
  localparam logic [4:0] CNT_SEEKDIST = 5'd5;
  localparam logic [4:0] CNT_BACK     = 5'd6;
  localparam logic [4:0] CNT_HIST0    = 5'd7;
  localparam logic [4:0] CNT_MAPS     = 5'd13;
  localparam logic [4:0] CNT_MAPBYTES = 5'd14;
  localparam logic [4:0] CNT_FIRST    = 5'd15;
  localparam logic [4:0] CNT_LAST     = 5'd16;
  localparam int STATS_PER_REC = 17;

  // histogram bucket limits
  localparam logic [31:0] BKT_LIM0 = 32'(4 * 1024);
  localparam logic [31:0] BKT_LIM1 = 32'(16 * 1024);
  localparam logic [31:0] BKT_LIM2 = 32'(64 * 1024);
  localparam logic [31:0] BKT_LIM3 = 32'(256 * 1024);
  localparam logic [31:0] BKT_LIM4 = 32'(1024 * 1024);

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]       op;
    logic [31:0]      handle;
    logic [31:0]      source_handle;
    logic [REC_W-1:0] file_index;
    logic [31:0]      got_bytes;
    logic [31:0]      elapsed_ticks;
    logic [63:0]      now_tick;
    logic [47:0]      seek_target;
    logic [31:0]      view_bytes;
    logic [4:0]       stat_select;
    logic [2:0]       bucket;
    logic             handle_nz;
    logic             source_nz;
    logic             file_ok;
    logic             select_ok;
  } item_t;

  // flow status seen by the front
  typedef struct packed {
    logic full;
    logic clearing;
  } flow_t;

endpackage

[sv/hkst_front.sv]
// front end: accepts items and classifies them for the back end
// depends on hkst_pkg
module hkst_front #(
  parameter int FILE_ENTRIES = hkst_pkg::FILE_ENTRIES_DEF
) (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              op,
  input  logic [31:0]             handle,
  input  logic [31:0]             source_handle,
  input  logic [8:0]              file_index,
  input  logic [31:0]             requested_bytes,
  input  logic [31:0]             got_bytes,
  input  logic [31:0]             elapsed_ticks,
  input  logic [63:0]             now_tick,
  input  logic [47:0]             seek_target,
  input  logic [31:0]             view_bytes,
  input  logic [4:0]              stat_select,
  input  hkst_pkg::flow_t         flow,
  output logic                    push,
  output hkst_pkg::item_t         item
);

  logic [2:0] bucket;

  // request size bucket
  always_comb begin
    if (requested_bytes <= hkst_pkg::BKT_LIM0) bucket = 3'd0;
    else if (requested_bytes <= hkst_pkg::BKT_LIM1) bucket = 3'd1;
    else if (requested_bytes <= hkst_pkg::BKT_LIM2) bucket = 3'd2;
    else if (requested_bytes <= hkst_pkg::BKT_LIM3) bucket = 3'd3;
    else if (requested_bytes <= hkst_pkg::BKT_LIM4) bucket = 3'd4;
    else bucket = 3'd5;
  end

  // hold off while the queue is full or the table is being cleared
  assign in_stall = flow.full || flow.clearing;
  assign push     = in_valid && !in_stall;

  // classified item
  always_comb begin
    item.op            = op;
    item.handle        = handle;
    item.source_handle = source_handle;
    item.file_index    = file_index;
    item.got_bytes     = got_bytes;
    item.elapsed_ticks = elapsed_ticks;
    item.now_tick      = now_tick;
    item.seek_target   = seek_target;
    item.view_bytes    = view_bytes;
    item.stat_select   = stat_select;
    item.bucket        = bucket;
    item.handle_nz     = handle != 32'd0;
    item.source_nz     = source_handle != 32'd0;
    item.file_ok       = 32'(file_index) < FILE_ENTRIES;
    item.select_ok     = stat_select <= hkst_pkg::CNT_LAST;
  end

endmodule

[sv/hkst_queue.sv]
// two entry queue between front and back ends
// depends on hkst_pkg
module hkst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hkst_pkg::item_t push_item,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output hkst_pkg::item_t q_item
);

  hkst_pkg::item_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign q_valid = count != 2'd0;
  assign q_full  = count == 2'd2;
  assign q_item  = slots[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_item;
  end

endmodule

[sv/hkst_back.sv]
// back end: handle table probing, counter updates and result register
// depends on hkst_pkg
module hkst_back #(
  parameter int FILE_ENTRIES = hkst_pkg::FILE_ENTRIES_DEF,
  parameter int HANDLE_SLOTS = hkst_pkg::HANDLE_SLOTS_DEF,
  parameter int PROBE_LIMIT  = hkst_pkg::PROBE_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  hkst_pkg::item_t q_item,
  output logic            pop,
  output logic            clearing,
  input  logic            out_stall,
  output logic            out_valid,
  output logic            tracked,
  output logic [8:0]      record_index,
  output logic [63:0]     stat_value
);

  localparam int RD      = (FILE_ENTRIES < 512) ? FILE_ENTRIES : 512;
  localparam int RW      = (RD > 1) ? $clog2(RD) : 1;
  localparam int SW      = $clog2(HANDLE_SLOTS);
  localparam int CW      = (SW > 9) ? SW : 9;
  localparam int CLR_LEN = (HANDLE_SLOTS > RD) ? HANDLE_SLOTS : RD;
  localparam int CDEPTH  = RD * hkst_pkg::STATS_PER_REC;
  localparam int CAW     = $clog2(CDEPTH);
  localparam int PCW     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam bit HS_POW2 = (HANDLE_SLOTS & (HANDLE_SLOTS - 1)) == 0;
  localparam int TW      = 32 + hkst_pkg::REC_W;

  localparam logic [SW:0] HS_N = (SW+1)'(HANDLE_SLOTS);

  // reciprocal of the slot count for the home slot remainder
  localparam int          QSH   = 30 + SW;
  localparam logic [31:0] RECIP = 32'((64'd1 << QSH) / 64'(HANDLE_SLOTS));

  // states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_HOME  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_VRD   = 4'd7;
  localparam logic [3:0] S_VCHK  = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OUSE  = 4'd10;
  localparam logic [3:0] S_CRD   = 4'd11;
  localparam logic [3:0] S_CWR   = 4'd12;
  localparam logic [3:0] S_STAT  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;
  localparam logic [3:0] S_FIX   = 4'd15;

  // counter update kinds
  localparam logic [3:0] K_ZERO = 4'd0;
  localparam logic [3:0] K_ONE  = 4'd1;
  localparam logic [3:0] K_INC  = 4'd2;
  localparam logic [3:0] K_ADDG = 4'd3;
  localparam logic [3:0] K_ADDT = 4'd4;
  localparam logic [3:0] K_ADDV = 4'd5;
  localparam logic [3:0] K_NOW  = 4'd6;
  localparam logic [3:0] K_DIST = 4'd7;
  localparam logic [3:0] K_BACK = 4'd8;

  typedef struct packed {
    logic       last;
    logic [4:0] off;
    logic [3:0] kind;
  } step_t;

  // counter steps of each operation
  function automatic step_t step_of(logic [2:0] op, logic first, logic [4:0] k,
                                    logic [2:0] bucket);
    step_t s;
    s.last = 1'b1;
    s.off  = hkst_pkg::CNT_OPENS;
    s.kind = K_ZERO;
    case (op)
      hkst_pkg::OP_OPEN: begin
        if (first) begin
          s.off  = k;
          s.last = k == hkst_pkg::CNT_LAST;
          if (k == hkst_pkg::CNT_OPENS) s.kind = K_ONE;
          else if (k == hkst_pkg::CNT_FIRST) s.kind = K_NOW;
          else s.kind = K_ZERO;
        end else begin
          s.kind = K_INC;
        end
      end
      hkst_pkg::OP_READ: begin
        s.last = 1'b0;
        case (k)
          5'd0: begin s.off = hkst_pkg::CNT_READS; s.kind = K_INC; end
          5'd1: begin s.off = hkst_pkg::CNT_BYTES; s.kind = K_ADDG; end
          5'd2: begin s.off = hkst_pkg::CNT_TICKS; s.kind = K_ADDT; end
          5'd3: begin s.off = hkst_pkg::CNT_HIST0 + {2'b00, bucket}; s.kind = K_INC; end
          default: begin s.off = hkst_pkg::CNT_LAST; s.kind = K_NOW; s.last = 1'b1; end
        endcase
      end
      hkst_pkg::OP_SEEK: begin
        s.last = 1'b0;
        case (k)
          5'd0: begin s.off = hkst_pkg::CNT_SEEKS; s.kind = K_INC; end
          5'd1: begin s.off = hkst_pkg::CNT_SEEKDIST; s.kind = K_DIST; end
          default: begin s.off = hkst_pkg::CNT_BACK; s.kind = K_BACK; s.last = 1'b1; end
        endcase
      end
      hkst_pkg::OP_VIEW: begin
        s.last = 1'b0;
        case (k)
          5'd0: begin s.off = hkst_pkg::CNT_MAPS; s.kind = K_INC; end
          5'd1: begin s.off = hkst_pkg::CNT_MAPBYTES; s.kind = K_ADDV; end
          default: begin s.off = hkst_pkg::CNT_LAST; s.kind = K_NOW; s.last = 1'b1; end
        endcase
      end
      default: s.last = 1'b1;
    endcase
    return s;
  endfunction

  // memories
  logic [TW-1:0] tab [HANDLE_SLOTS];
  logic          vld [RD];
  logic [63:0]   cnt [CDEPTH];
  logic [48:0]   ofs [RD];

  logic [TW-1:0] tab_q;
  logic          vld_q;
  logic [63:0]   cnt_q;
  logic [48:0]   ofs_q;

  logic          tab_we;
  logic [SW-1:0] tab_wa;
  logic [SW-1:0] tab_ra;
  logic [TW-1:0] tab_wd;
  logic          vld_we;
  logic [RW-1:0] vld_wa;
  logic          vld_wd;
  logic          cnt_we;
  logic [CAW-1:0] cnt_a;
  logic [63:0]   cnt_wd;
  logic          ofs_we;
  logic [48:0]   ofs_wd;

  // control and working registers
  logic [3:0]             state;
  logic [CW-1:0]          clr;
  hkst_pkg::item_t        it;
  logic [31:0]            key;
  logic                   purp_bind;
  logic [SW-1:0]          home;
  logic [SW-1:0]          slot;
  logic [PCW-1:0]         pcnt;
  logic [61:0]            prod;
  logic [SW:0]            rem;
  logic [hkst_pkg::REC_W-1:0] rec;
  logic                   first;
  logic [4:0]             step;
  logic [47:0]            seek_dist;
  logic                   back;
  logic                   res_tr;
  logic [hkst_pkg::REC_W-1:0] res_rec;
  logic [63:0]            res_stat;

  // derived values
  step_t       st;
  logic [4:0]  cnt_off;
  logic [31:0] tab_h;
  logic [hkst_pkg::REC_W-1:0] tab_r;
  logic        p_match;
  logic        p_empty;
  logic        p_last;
  logic [SW-1:0] slot_inc;
  logic [29:0]   hkey;
  logic [29:0]   quo;
  logic [29:0]   qn;
  logic [SW:0]   rem_fix;
  logic [47:0]   exp_ofs;
  logic          clr_tab;
  logic          clr_vld;

  assign clearing = state == S_CLEAR;
  assign pop      = (state == S_IDLE) && q_valid;

  assign st      = step_of(it.op, first, step, it.bucket);
  assign cnt_off = (it.op == hkst_pkg::OP_STAT) ? it.stat_select : st.off;
  assign cnt_a   = CAW'(rec[RW-1:0]) * CAW'(hkst_pkg::STATS_PER_REC) + CAW'(cnt_off);

  assign tab_h    = tab_q[TW-1:hkst_pkg::REC_W];
  assign tab_r    = tab_q[hkst_pkg::REC_W-1:0];
  assign p_match  = tab_h == key;
  assign p_empty  = tab_h == 32'd0;
  assign p_last   = pcnt == PCW'(PROBE_LIMIT - 1);
  assign slot_inc = (slot == SW'(HANDLE_SLOTS - 1)) ? '0 : slot + SW'(1);

  // home slot remainder: quotient estimate low by at most one, one fix-up
  assign hkey    = key[31:2];
  assign quo     = 30'(prod >> QSH);
  assign qn      = 30'(quo * 30'(HANDLE_SLOTS));
  assign rem_fix = (rem >= HS_N) ? rem - HS_N : rem;
  assign exp_ofs = ofs_q[47:0];
  assign clr_tab = {1'b0, clr} < (CW+1)'(HANDLE_SLOTS);
  assign clr_vld = {1'b0, clr} < (CW+1)'(RD);

  // memory port control
  always_comb begin
    tab_we = 1'b0;
    tab_wa = slot;
    tab_wd = {key, rec};
    tab_ra = slot;
    vld_we = 1'b0;
    vld_wa = rec[RW-1:0];
    vld_wd = 1'b1;
    cnt_we = 1'b0;
    cnt_wd = 64'd0;
    ofs_we = 1'b0;
    ofs_wd = 49'd0;
    case (state)
      S_CLEAR: begin
        tab_we = clr_tab;
        tab_wa = clr[SW-1:0];
        tab_wd = '0;
        vld_we = clr_vld;
        vld_wa = clr[RW-1:0];
        vld_wd = 1'b0;
      end
      S_PCHK: begin
        if (purp_bind) begin
          if (p_match || p_empty) begin
            tab_we = 1'b1;
          end else if (p_last) begin
            tab_we = 1'b1;
            tab_wa = home;
          end
        end
      end
      S_VCHK: begin
        if (it.op == hkst_pkg::OP_OPEN) begin
          vld_we = 1'b1;
          ofs_we = 1'b1;
        end
      end
      S_OUSE: begin
        if (it.op == hkst_pkg::OP_READ) begin
          ofs_we = ofs_q[48];
          ofs_wd = {1'b1, exp_ofs + 48'(it.got_bytes)};
        end else if (it.op == hkst_pkg::OP_SEEK) begin
          ofs_we = 1'b1;
          ofs_wd = {1'b1, it.seek_target};
        end
      end
      S_CWR: begin
        cnt_we = 1'b1;
        case (st.kind)
          K_ONE:   cnt_wd = 64'd1;
          K_INC:   cnt_wd = cnt_q + 64'd1;
          K_ADDG:  cnt_wd = cnt_q + 64'(it.got_bytes);
          K_ADDT:  cnt_wd = cnt_q + 64'(it.elapsed_ticks);
          K_ADDV:  cnt_wd = cnt_q + 64'(it.view_bytes);
          K_NOW:   cnt_wd = it.now_tick;
          K_DIST:  cnt_wd = cnt_q + 64'(seek_dist);
          K_BACK:  cnt_wd = cnt_q + 64'(back);
          default: cnt_wd = 64'd0;
        endcase
      end
      default: begin
      end
    endcase
  end

  // memory arrays, read data registered
  always_ff @(posedge clk) begin
    if (tab_we) tab[tab_wa] <= tab_wd;
    tab_q <= tab[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (vld_we) vld[vld_wa] <= vld_wd;
    vld_q <= vld[rec[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt[cnt_a] <= cnt_wd;
    cnt_q <= cnt[cnt_a];
  end

  always_ff @(posedge clk) begin
    if (ofs_we) ofs[rec[RW-1:0]] <= ofs_wd;
    ofs_q <= ofs[rec[RW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register hand-over
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(CLR_LEN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            it    <= q_item;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_tr   <= 1'b0;
          res_rec  <= '0;
          res_stat <= 64'd0;
          purp_bind <= 1'b0;
          case (it.op)
            hkst_pkg::OP_OPEN, hkst_pkg::OP_STAT: begin
              if ((it.op == hkst_pkg::OP_STAT || it.handle_nz) && it.file_ok) begin
                rec   <= it.file_index;
                state <= S_VRD;
              end else begin
                state <= S_DONE;
              end
            end
            hkst_pkg::OP_READ, hkst_pkg::OP_SEEK, hkst_pkg::OP_VIEW: begin
              if (it.handle_nz) begin
                key   <= it.handle;
                state <= S_HOME;
              end else begin
                state <= S_DONE;
              end
            end
            hkst_pkg::OP_MAP: begin
              if (it.handle_nz && it.source_nz) begin
                key   <= it.source_handle;
                state <= S_HOME;
              end else begin
                state <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_HOME: begin
          pcnt <= '0;
          if (HS_POW2) begin
            home  <= key[2 +: SW];
            slot  <= key[2 +: SW];
            state <= S_PRD;
          end else begin
            prod  <= 62'(hkey) * 62'(RECIP);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= (SW+1)'(hkey - qn);
          state <= S_FIX;
        end
        S_FIX: begin
          home  <= rem_fix[SW-1:0];
          slot  <= rem_fix[SW-1:0];
          state <= S_PRD;
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (purp_bind) begin
            if (p_match || p_empty || p_last) begin
              res_tr  <= 1'b1;
              res_rec <= rec;
              state   <= S_DONE;
            end else begin
              slot  <= slot_inc;
              pcnt  <= pcnt + PCW'(1);
              state <= S_PRD;
            end
          end else if (p_match) begin
            rec <= tab_r;
            if (it.op == hkst_pkg::OP_MAP) begin
              key       <= it.handle;
              purp_bind <= 1'b1;
              state     <= S_HOME;
            end else begin
              state <= S_ORD;
            end
          end else if (p_empty || p_last) begin
            state <= S_DONE;
          end else begin
            slot  <= slot_inc;
            pcnt  <= pcnt + PCW'(1);
            state <= S_PRD;
          end
        end
        S_VRD: state <= S_VCHK;
        S_VCHK: begin
          step <= 5'd0;
          if (it.op == hkst_pkg::OP_OPEN) begin
            first <= !vld_q;
            state <= S_CRD;
          end else if (!vld_q) begin
            state <= S_DONE;
          end else if (!it.select_ok) begin
            res_tr  <= 1'b1;
            res_rec <= rec;
            state   <= S_DONE;
          end else begin
            state <= S_CRD;
          end
        end
        S_ORD: state <= S_OUSE;
        S_OUSE: begin
          // seek distance from the expected offset, if known
          if (ofs_q[48]) begin
            back      <= it.seek_target < exp_ofs;
            seek_dist <= (it.seek_target < exp_ofs) ? exp_ofs - it.seek_target
                                                    : it.seek_target - exp_ofs;
          end else begin
            back      <= 1'b0;
            seek_dist <= 48'd0;
          end
          step  <= 5'd0;
          state <= S_CRD;
        end
        S_CRD: state <= (it.op == hkst_pkg::OP_STAT) ? S_STAT : S_CWR;
        S_CWR: begin
          step <= step + 5'd1;
          if (!st.last) begin
            state <= S_CRD;
          end else if (it.op == hkst_pkg::OP_OPEN) begin
            key       <= it.handle;
            purp_bind <= 1'b1;
            state     <= S_HOME;
          end else begin
            res_tr  <= 1'b1;
            res_rec <= rec;
            state   <= S_DONE;
          end
        end
        S_STAT: begin
          res_tr   <= 1'b1;
          res_rec  <= rec;
          res_stat <= cnt_q;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            tracked      <= res_tr;
            record_index <= res_rec;
            stat_value   <= res_stat;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/handle_keyed_io_statistics_table_unit.sv]
// Per-file I/O statistics keyed by handle through a linear-probe handle table.
// After reset the block clears its handle table and record valid bits, one
// entry a cycle, over max(HANDLE_SLOTS, FILE_ENTRIES capped at 512) entries
// (4096 by default) and takes no item meanwhile. Items are then carried out
// one at a time: each probe of the handle table is a read on its single read
// port (up to PROBE_LIMIT probes per lookup or bind), and each counter update
// is a read-modify-write on the counter memory (states S_CRD, then S_CWR).
// When HANDLE_SLOTS is not a power of two the home slot comes from a
// reciprocal multiplication, through the states S_DIV and S_FIX. A two-item
// queue sits before the sequencer and a result register after it, so input
// and output stall independently.
`include "handle_keyed_io_statistics_table_unit_defines.svh"

module handle_keyed_io_statistics_table_unit #(
  parameter int FILE_ENTRIES = hkst_pkg::FILE_ENTRIES_DEF,
  parameter int HANDLE_SLOTS = hkst_pkg::HANDLE_SLOTS_DEF,
  parameter int PROBE_LIMIT  = hkst_pkg::PROBE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [31:0] handle,
  input  logic [31:0] source_handle,
  input  logic [8:0]  file_index,
  input  logic [31:0] requested_bytes,
  input  logic [31:0] got_bytes,
  input  logic [31:0] elapsed_ticks,
  input  logic [63:0] now_tick,
  input  logic [47:0] seek_target,
  input  logic [31:0] view_bytes,
  input  logic [4:0]  stat_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tracked,
  output logic [8:0]  record_index,
  output logic [63:0] stat_value
);

  hkst_pkg::flow_t flow;
  hkst_pkg::item_t push_item;
  hkst_pkg::item_t q_item;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  logic            clearing;

  assign flow.full     = q_full;
  assign flow.clearing = clearing;

  // classify incoming items
  hkst_front #(
    .FILE_ENTRIES(FILE_ENTRIES)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .handle         (handle),
    .source_handle  (source_handle),
    .file_index     (file_index),
    .requested_bytes(requested_bytes),
    .got_bytes      (got_bytes),
    .elapsed_ticks  (elapsed_ticks),
    .now_tick       (now_tick),
    .seek_target    (seek_target),
    .view_bytes     (view_bytes),
    .stat_select    (stat_select),
    .flow           (flow),
    .push           (push),
    .item           (push_item)
  );

  // queue between front and back
  hkst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_item   (q_item)
  );

  // table and counter sequencer
  hkst_back #(
    .FILE_ENTRIES(FILE_ENTRIES),
    .HANDLE_SLOTS(HANDLE_SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .clearing    (clearing),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .tracked     (tracked),
    .record_index(record_index),
    .stat_value  (stat_value)
  );

  // checks
  `HKST_NEVER(a_no_push_in_clear, push && clearing, "item taken during clearing pass")
  `HKST_IMPLY(a_no_overflow, q_full && !pop, !push, "queue overflow")
  `HKST_IMPLY(a_quiet_clear, clearing, !q_valid && !out_valid && !pop, "activity while clearing")

endmodule

[test/handle_keyed_io_statistics_table_unit_tb.sv]
// Self-checking testbench for the handle keyed i/o statistics table.
// Depends on hkst_pkg and handle_keyed_io_statistics_table_unit; a built-in
// predictor of the handle table and per-file counters checks every result item.
module handle_keyed_io_statistics_table_unit_tb;

  localparam int NFILES = 512;
  localparam int NSLOTS = 4096;
  localparam int NPROBE = 8;
  localparam int CYCLE_LIMIT = 900000;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [31:0] handle = '0;
  logic [31:0] source_handle = '0;
  logic [8:0] file_index = '0;
  logic [31:0] requested_bytes = '0;
  logic [31:0] got_bytes = '0;
  logic [31:0] elapsed_ticks = '0;
  logic [63:0] now_tick = '0;
  logic [47:0] seek_target = '0;
  logic [31:0] view_bytes = '0;
  logic [4:0] stat_select = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic tracked;
  logic [8:0] record_index;
  logic [63:0] stat_value;

  handle_keyed_io_statistics_table_unit uut (.*);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic       trk;
    logic [8:0] rec;
    logic [63:0] val;
  } outcome_t;

  // predictor state
  logic [31:0] slot_handle [NSLOTS];
  logic [8:0]  slot_rec [NSLOTS];
  bit          file_open [NFILES];
  logic [63:0] file_stats [NFILES][17];
  logic [48:0] file_offset [NFILES];
  outcome_t    pending_outcomes [$];
  int          errors = 0;
  int          cycles = 0;
  logic [31:0] live_handles [$];
  logic [63:0] clock_now = 64'd1000;

  function automatic int home_of(logic [31:0] h);
    return int'((h >> 2) % NSLOTS);
  endfunction

  function automatic void bind_slot(logic [31:0] h, logic [8:0] r);
    int s;
    for (int i = 0; i < NPROBE; i++) begin
      s = (home_of(h) + i) % NSLOTS;
      if (slot_handle[s] == h || slot_handle[s] == 0) begin
        slot_handle[s] = h;
        slot_rec[s] = r;
        return;
      end
    end
    slot_handle[home_of(h)] = h;
    slot_rec[home_of(h)] = r;
  endfunction

  function automatic bit find_slot(logic [31:0] h, output logic [8:0] r);
    int s;
    r = '0;
    if (h == 0) return 0;
    for (int i = 0; i < NPROBE; i++) begin
      s = (home_of(h) + i) % NSLOTS;
      if (slot_handle[s] == h) begin
        r = slot_rec[s];
        return 1;
      end
      if (slot_handle[s] == 0) return 0;
    end
    return 0;
  endfunction

  function automatic int size_bucket(logic [31:0] n);
    if (n <= hkst_pkg::BKT_LIM0) return 0;
    if (n <= hkst_pkg::BKT_LIM1) return 1;
    if (n <= hkst_pkg::BKT_LIM2) return 2;
    if (n <= hkst_pkg::BKT_LIM3) return 3;
    if (n <= hkst_pkg::BKT_LIM4) return 4;
    return 5;
  endfunction

  // apply one item to the predicted state and return the expected result
  function automatic outcome_t apply_event();
    outcome_t o;
    logic [8:0] r;
    logic [47:0] ofs;
    o = '{1'b0, 9'd0, 64'd0};
    r = '0;
    case (op)
      hkst_pkg::OP_OPEN: if (handle != 0) begin
        r = file_index;
        if (!file_open[r]) begin
          for (int k = 0; k < 17; k++) file_stats[r][k] = 0;
          file_stats[r][hkst_pkg::CNT_FIRST] = now_tick;
          file_open[r] = 1;
        end
        file_stats[r][hkst_pkg::CNT_OPENS]++;
        file_offset[r] = '0;
        bind_slot(handle, r);
        o.trk = 1;
      end
      hkst_pkg::OP_READ: if (find_slot(handle, r)) begin
        file_stats[r][hkst_pkg::CNT_READS]++;
        file_stats[r][hkst_pkg::CNT_BYTES] += got_bytes;
        file_stats[r][hkst_pkg::CNT_TICKS] += elapsed_ticks;
        file_stats[r][hkst_pkg::CNT_HIST0 + size_bucket(requested_bytes)]++;
        file_stats[r][hkst_pkg::CNT_LAST] = now_tick;
        if (file_offset[r][48])
          file_offset[r] = {1'b1, file_offset[r][47:0] + 48'(got_bytes)};
        o.trk = 1;
      end
      hkst_pkg::OP_SEEK: if (find_slot(handle, r)) begin
        file_stats[r][hkst_pkg::CNT_SEEKS]++;
        if (file_offset[r][48]) begin
          ofs = file_offset[r][47:0];
          if (seek_target < ofs) begin
            file_stats[r][hkst_pkg::CNT_BACK]++;
            file_stats[r][hkst_pkg::CNT_SEEKDIST] += 64'(ofs - seek_target);
          end else
            file_stats[r][hkst_pkg::CNT_SEEKDIST] += 64'(seek_target - ofs);
        end
        file_offset[r] = {1'b1, seek_target};
        o.trk = 1;
      end
      hkst_pkg::OP_MAP: if (handle != 0 && find_slot(source_handle, r)) begin
        bind_slot(handle, r);
        o.trk = 1;
      end
      hkst_pkg::OP_VIEW: if (find_slot(handle, r)) begin
        file_stats[r][hkst_pkg::CNT_MAPS]++;
        file_stats[r][hkst_pkg::CNT_MAPBYTES] += view_bytes;
        file_stats[r][hkst_pkg::CNT_LAST] = now_tick;
        o.trk = 1;
      end
      hkst_pkg::OP_STAT: if (file_open[file_index]) begin
        r = file_index;
        o.trk = 1;
        if (stat_select <= hkst_pkg::CNT_LAST) o.val = file_stats[r][stat_select];
      end
      default: ;
    endcase
    if (o.trk) o.rec = r;
    return o;
  endfunction

  // send one item; prediction runs at its acceptance edge
  task automatic send_event(logic [2:0] o_op, logic [31:0] h, logic [31:0] src,
                            logic [8:0] fi, logic [31:0] req, logic [31:0] got,
                            logic [31:0] dt, logic [47:0] tgt, logic [31:0] vb,
                            logic [4:0] sel);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    clock_now += $urandom_range(1, 500);
    op <= o_op; handle <= h; source_handle <= src; file_index <= fi;
    requested_bytes <= req; got_bytes <= got; elapsed_ticks <= dt;
    now_tick <= clock_now; seek_target <= tgt; view_bytes <= vb;
    stat_select <= sel; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(apply_event());
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin
    outcome_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = pending_outcomes.pop_front();
          if (tracked !== e.trk) begin
            $error("tracked exp %0d got %0d", e.trk, tracked); errors++;
          end
          if (record_index !== e.rec) begin
            $error("record_index exp %0d got %0d", e.rec, record_index); errors++;
          end
          if (stat_value !== e.val) begin
            $error("stat_value exp %0h got %0h", e.val, stat_value); errors++;
          end
        end
      end
      if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
      else if (out_stall && $urandom_range(0, 2) == 0) out_stall <= 1'b0;
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] fresh_handle();
    logic [31:0] h;
    h = $urandom();
    if (h == 0) h = 1;
    return h;
  endfunction

  function automatic logic [31:0] pick_handle();
    if (live_handles.size() == 0 || $urandom_range(0, 9) == 0) return fresh_handle();
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 70000);
      1: return $urandom_range(0, 2000000);
      2: return $urandom();
      default: return hkst_pkg::BKT_LIM0 << (2 * $urandom_range(0, 4));
    endcase
  endfunction

  // directed: extremes, every op and the corner cases
  task automatic test_directed();
    send_event(hkst_pkg::OP_STAT, 32'd5, 0, 9'd3, 0, 0, 0, 0, 0, 5'd0);
    send_event(hkst_pkg::OP_OPEN, 32'd0, 0, 9'd3, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_OPEN, 32'hFFFF_FFFF, 0, 9'd511, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_OPEN, 32'd4, 0, 9'd0, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_READ, 32'd4, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 0, 0, 0);
    send_event(hkst_pkg::OP_READ, 32'd4, 0, 0, hkst_pkg::BKT_LIM0, 32'd100, 1, 0, 0, 0);
    send_event(hkst_pkg::OP_SEEK, 32'd4, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 0);
    send_event(hkst_pkg::OP_READ, 32'd4, 0, 0, hkst_pkg::BKT_LIM4, 32'd10, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_SEEK, 32'd4, 0, 0, 0, 0, 0, 48'd0, 0, 0);
    send_event(hkst_pkg::OP_SEEK, 32'd4, 0, 0, 0, 0, 0, 48'd77, 0, 0);
    send_event(hkst_pkg::OP_MAP, 32'd0, 32'd4, 0, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_MAP, 32'd8, 32'd999, 0, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_MAP, 32'd8, 32'd4, 0, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_VIEW, 32'd8, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_event(hkst_pkg::OP_READ, 32'd12345, 0, 0, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_READ, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_event(OP_BAD6, 32'd4, 0, 9'd0, 0, 0, 0, 0, 0, 0);
    send_event(OP_BAD7, 32'd4, 0, 9'd0, 0, 0, 0, 0, 0, 0);
    send_event(hkst_pkg::OP_STAT, 0, 0, 9'd0, 0, 0, 0, 0, 0, 5'd31);
    for (int s = 0; s <= 16; s += 3)
      send_event(hkst_pkg::OP_STAT, 0, 0, 9'd0, 0, 0, 0, 0, 0, 5'(s));
    live_handles.push_back(32'd4);
    live_handles.push_back(32'd8);
    live_handles.push_back(32'hFFFF_FFFF);
  endtask

  // colliding handles share a home slot, beyond the probe limit
  task automatic test_probe_overflow();
    for (int i = 0; i < 10; i++)
      send_event(hkst_pkg::OP_OPEN, 32'h0004_0000 * (i + 1) + 32'd16, 0, 9'(20 + i),
                 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      send_event(hkst_pkg::OP_READ, 32'h0004_0000 * (i + 1) + 32'd16, 0, 0, 100, 1, 1,
                 0, 0, 0);
    send_event(hkst_pkg::OP_STAT, 0, 0, 9'd29, 0, 0, 0, 0, 0, hkst_pkg::CNT_READS);
  endtask

  // random mix, mostly on bound handles and a small set of files
  task automatic test_random(int n);
    logic [31:0] h;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          h = fresh_handle();
          if (live_handles.size() < 64) live_handles.push_back(h);
          send_event(hkst_pkg::OP_OPEN, h, 0,
                     ($urandom_range(0, 7) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 15)),
                     0, 0, 0, 0, 0, 0);
        end
        2, 3, 4: send_event(hkst_pkg::OP_READ, pick_handle(), 0, 0, rand_size(),
                            rand_size(), $urandom(), 0, 0, 0);
        5: send_event(hkst_pkg::OP_SEEK, pick_handle(), 0, 0, 0, 0, 0,
                      {16'($urandom()), 32'($urandom())} >> $urandom_range(0, 40), 0, 0);
        6: begin
          h = fresh_handle();
          if (live_handles.size() < 64) live_handles.push_back(h);
          send_event(hkst_pkg::OP_MAP, h, pick_handle(), 0, 0, 0, 0, 0, 0, 0);
        end
        7: send_event(hkst_pkg::OP_VIEW, pick_handle(), 0, 0, 0, 0, 0, 0, $urandom(), 0);
        8, 9, 10: send_event(hkst_pkg::OP_STAT, 0, 0, 9'($urandom_range(0, 17)),
                             0, 0, 0, 0, 0, 5'($urandom_range(0, 18)));
        default: send_event(3'($urandom()), $urandom(), $urandom(), 9'($urandom()),
                            $urandom(), $urandom(), $urandom(), 48'($urandom()),
                            $urandom(), 5'($urandom()));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_probe_overflow();
    test_random(620);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
